// File: src/strided_view_address_generator_top_macros.svh
// Assertion macros for the strided view address generator.
// No dependencies; included by modules that carry assertions.
`ifndef STRIDED_VIEW_ADDRESS_GENERATOR_TOP_MACROS_SVH
`define STRIDED_VIEW_ADDRESS_GENERATOR_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset
`define SVAG_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("svag assertion failed: same-cycle check");

// Next-cycle implication, disabled during reset
`define SVAG_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("svag assertion failed: next-cycle check");

`endif

// File: src/svag_pkg.sv
// Package for the strided view address generator: widths, register codes
// and field helpers. No dependencies.
`timescale 1ns / 1ps

package svag_pkg;

  localparam int MAX_DIMS   = 4;
  localparam int DIM_BITS   = 2;   // index into the per-dimension arrays
  localparam int INDEX_BITS = 32;
  localparam int POS_BITS   = 48;
  localparam int CNT_BITS   = 16;
  localparam int OUT_BITS   = 32;
  localparam int CFG_BITS   = 64;
  localparam int CFG_IDX_BITS = 3;
  localparam int PROD_BITS  = 33;  // 17-bit signed times 16-bit signed

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_NUM_DIMS    = 3'd0,
    REG_BASE_OFFSET = 3'd1,
    REG_DIM_EXTENTS = 3'd2,
    REG_DIM_STRIDES = 3'd3
  } cfg_reg_t;

  typedef logic [POS_BITS-1:0] pos_t;
  typedef logic [CNT_BITS-1:0] cnt_t;

  // Extent of one slot; zero is treated as one
  function automatic cnt_t extent_of(input logic [CFG_BITS-1:0] exts,
                                     input logic [DIM_BITS-1:0] slot);
    cnt_t e;
    e = exts[CNT_BITS*slot +: CNT_BITS];
    return (e == '0) ? cnt_t'(1) : e;
  endfunction

  // Raw 16-bit stride of one slot
  function automatic cnt_t stride_of(input logic [CFG_BITS-1:0] strs,
                                     input logic [DIM_BITS-1:0] slot);
    return strs[CNT_BITS*slot +: CNT_BITS];
  endfunction

  // Stride sign-extended to position width
  function automatic pos_t stride_ext(input cnt_t s);
    return {{(POS_BITS-CNT_BITS){s[CNT_BITS-1]}}, s};
  endfunction

endpackage

// File: src/svag_if.sv
// Handshake interfaces for the request and result channels.
// Depends on svag_pkg for field widths.
`timescale 1ns / 1ps

interface svag_req_if import svag_pkg::*; ();
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink (input valid, input restart, output ready);
endinterface

interface svag_rsp_if import svag_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [OUT_BITS-1:0] src_index;
  logic [OUT_BITS-1:0] dst_index;
  logic                out_of_range;
  logic                last;

  modport source (output valid, output src_index, output dst_index,
                  output out_of_range, output last, input ready);
  modport sink (input valid, input src_index, input dst_index,
                input out_of_range, input last, output ready);
endinterface

// File: src/strided_view_address_generator_top.sv
// A request accepted in an active or restarted walk has its result registered in the next cycle.
// Throughput: one request per cycle while results are taken; a waiting result stalls requests.
// Each configuration write starts a recompute of the per-dimension
// step table through one shared multiplier; requests stall during it.
// Reset (synchronous, active high) clears registers, walk state and table.
// Depends on svag_pkg, svag_if and the macros header.
`timescale 1ns / 1ps
`include "strided_view_address_generator_top_macros.svh"

module strided_view_address_generator_top import svag_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [CFG_BITS-1:0]     cfg_data,
  svag_req_if.sink                req,
  svag_rsp_if.source              rsp
);

  // Configuration registers
  logic [2:0]          num_dims;
  logic [31:0]         base_offset;
  logic [CFG_BITS-1:0] dim_extents;
  logic [CFG_BITS-1:0] dim_strides;

  // Step table: position delta when slot k advances and slots below wrap
  pos_t                      delta [MAX_DIMS];
  logic                      busy;
  logic [2:0]                phase;
  pos_t                      acc;
  logic signed [PROD_BITS-1:0] prod;

  // Walk state
  cnt_t                dim_counters [MAX_DIMS];
  pos_t                source_position;
  logic [OUT_BITS-1:0] emitted_count;
  logic                walk_active;

  // Result register
  logic                rsp_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_dims    <= '0;
      base_offset <= '0;
      dim_extents <= '0;
      dim_strides <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_NUM_DIMS:    num_dims    <= cfg_data[2:0];
        REG_BASE_OFFSET: base_offset <= cfg_data[31:0];
        REG_DIM_EXTENTS: dim_extents <= cfg_data;
        REG_DIM_STRIDES: dim_strides <= cfg_data;
        default: ;
      endcase
    end
  end

  // Shared multiplier: (1 - extent) * stride for the slot being processed
  logic [DIM_BITS-1:0]          mul_slot;
  logic [DIM_BITS-1:0]          dly_slot;
  logic [2:0]                   dly_phase;
  logic signed [CNT_BITS:0]     ext_m1;
  logic signed [CNT_BITS-1:0]   mul_str;
  logic signed [PROD_BITS-1:0]  mul_out;

  assign mul_slot  = phase[DIM_BITS-1:0];
  assign dly_phase = phase - 3'd1;
  assign dly_slot  = dly_phase[DIM_BITS-1:0];
  assign ext_m1    = signed'(17'd1 - {1'b0, extent_of(dim_extents, mul_slot)});
  assign mul_str   = signed'(stride_of(dim_strides, mul_slot));
  assign mul_out   = PROD_BITS'(ext_m1) * PROD_BITS'(mul_str);

  // Table recompute sequencer, restarted by every configuration write
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      phase <= '0;
      for (int i = 0; i < MAX_DIMS; i++) delta[i] <= '0;
    end else if (cfg_we) begin
      busy  <= 1'b1;
      phase <= '0;
    end else if (busy) begin
      if (phase == 3'd0) begin
        acc  <= '0;
        prod <= mul_out;
      end else begin
        delta[dly_slot] <= stride_ext(stride_of(dim_strides, dly_slot)) + acc;
        acc  <= acc + POS_BITS'(prod);
        prod <= mul_out;
      end
      phase <= phase + 3'd1;
      if (phase == 3'(MAX_DIMS)) busy <= 1'b0;
    end
  end

  // Request handling
  logic                req_acc;
  logic [2:0]          used_dims;
  cnt_t                cur_cnt [MAX_DIMS];
  cnt_t                cnt_next [MAX_DIMS];
  pos_t                cur_pos;
  pos_t                pos_next;
  pos_t                step_delta;
  logic [OUT_BITS-1:0] cur_count;
  logic                cur_active;
  logic                is_last;
  logic                found;
  logic                produce;

  assign req.ready  = !busy && (!rsp_valid || rsp.ready);
  assign req_acc    = req.valid && req.ready;
  assign used_dims  = (num_dims > 3'(MAX_DIMS)) ? 3'(MAX_DIMS) : num_dims;
  assign cur_pos    = req.restart ? POS_BITS'(base_offset) : source_position;
  assign cur_count  = req.restart ? '0 : emitted_count;
  assign cur_active = req.restart || walk_active;
  assign produce    = req_acc && cur_active;

  // Carry chain: lowest slot that can still count up advances, those below wrap
  always_comb begin
    found      = 1'b0;
    step_delta = '0;
    for (int s = 0; s < MAX_DIMS; s++) begin
      cur_cnt[s]  = req.restart ? '0 : dim_counters[s];
      cnt_next[s] = cur_cnt[s];
      if (!found && (3'(s) < used_dims)) begin
        if (({1'b0, cur_cnt[s]} + 17'd1) <
            {1'b0, extent_of(dim_extents, DIM_BITS'(s))}) begin
          found       = 1'b1;
          cnt_next[s] = cur_cnt[s] + cnt_t'(1);
          step_delta  = delta[s];
        end else begin
          cnt_next[s] = '0;
        end
      end
    end
    is_last  = !found;
    pos_next = cur_pos + step_delta;
  end

  // Walk state update
  always_ff @(posedge clk) begin
    if (rst) begin
      walk_active     <= 1'b0;
      source_position <= '0;
      emitted_count   <= '0;
      for (int i = 0; i < MAX_DIMS; i++) dim_counters[i] <= '0;
    end else if (produce) begin
      if (is_last) begin
        walk_active     <= 1'b0;
        source_position <= cur_pos;
        emitted_count   <= cur_count;
        for (int i = 0; i < MAX_DIMS; i++) dim_counters[i] <= cur_cnt[i];
      end else begin
        walk_active     <= 1'b1;
        source_position <= pos_next;
        emitted_count   <= cur_count + 32'd1;
        for (int i = 0; i < MAX_DIMS; i++) dim_counters[i] <= cnt_next[i];
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (produce) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (produce) begin
      rsp.src_index    <= cur_pos[INDEX_BITS-1:0];
      rsp.dst_index    <= cur_count;
      rsp.out_of_range <= |cur_pos[POS_BITS-1:INDEX_BITS];
      rsp.last         <= is_last;
    end
  end

  assign rsp.valid = rsp_valid;

  // Checks
  `SVAG_ASSERT_NOW(a_busy_stalls, clk, rst, busy, !req.ready)
  `SVAG_ASSERT_NEXT(a_cfg_starts_recompute, clk, rst, cfg_we, busy)
  `SVAG_ASSERT_NEXT(a_restart_first_elem, clk, rst, req_acc && req.restart,
                    rsp_valid && (rsp.dst_index == '0))
  `SVAG_ASSERT_NEXT(a_last_ends_walk, clk, rst, produce && is_last, !walk_active)

endmodule
